// ===== rtl/core/key_gesture_tracker_unit_defines.svh =====
`ifndef KEY_GESTURE_TRACKER_UNIT_DEFINES_SVH
`define KEY_GESTURE_TRACKER_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define KGT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequent in the same cycle
`define KGT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define KGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/kgt_pkg.sv =====
`default_nettype none

package kgt_pkg;

  localparam int NUM_KEYS_DEF = 512;

  localparam int KIND_W    = 2;
  localparam int KEY_W     = 9;
  localparam int ELAPSED_W = 20;
  localparam int MASK_W    = 7;
  localparam int GS_W      = 3;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED    = 2'd2;

  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 32'd500000;
  localparam logic [TIME_W-1:0] DOUBLE_WIN_RESET = 32'd250000;

  localparam logic [GS_W-1:0] G_INITIAL = 3'd0;
  localparam logic [GS_W-1:0] G_PRESS   = 3'd1;
  localparam logic [GS_W-1:0] G_CLICK   = 3'd2;
  localparam logic [GS_W-1:0] G_DPRESS  = 3'd3;
  localparam logic [GS_W-1:0] G_DCLICK  = 3'd4;
  localparam logic [GS_W-1:0] G_LPRESS  = 3'd5;
  localparam logic [GS_W-1:0] G_LCLICK  = 3'd6;

  typedef struct packed {
    logic [GS_W-1:0]   gesture;
    logic [TIME_W-1:0] state_timer;
    logic [TIME_W-1:0] event_timer;
    logic              level;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] long_press;
    logic [TIME_W-1:0] double_win;
  } thresh_t;

endpackage

`default_nettype wire

// ===== rtl/core/key_gesture_tracker_unit.sv =====
// change: read, write-back in ST_CHANGE; query: read, result loaded when out_ready allows
// tick: one read-modify-write per key entry; no new request is taken until the sweep ends
// the sweep uses the separate read and write ports of the key memory together
// reset: clears all key entries, one per cycle, with no request taken until the pass ends
// config writes are taken in every cycle outside reset, also during the clearing pass
`default_nettype none

module key_gesture_tracker_unit #(
  parameter int NUM_KEYS = kgt_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kgt_pkg::KIND_W-1:0]        kind,
  input  logic [kgt_pkg::KEY_W-1:0]         key,
  input  logic                              pressed,
  input  logic [kgt_pkg::ELAPSED_W-1:0]     elapsed,
  input  logic [kgt_pkg::MASK_W-1:0]        state_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kgt_pkg::GS_W-1:0]          gesture_state,
  output logic                              matches_res,
  output logic                              held,
  output logic [kgt_pkg::TIME_W-1:0]        held_time,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kgt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kgt_pkg::CFG_W-1:0]         cfg_data
);
  import kgt_pkg::*;

  `include "key_gesture_tracker_unit_defines.svh"

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_KEYS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_CHANGE = 5'b00100,
    ST_QUERY  = 5'b01000,
    ST_SWEEP  = 5'b10000
  } state_t;

  state_t st, st_next;
  logic [AW-1:0] idx, idx_next;

  entry_t mem [NUM_KEYS];
  entry_t rd_data;
  entry_t wr_data;
  entry_t adv;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  thresh_t thresh;
  logic    blocked;

  logic                 item_in_range;
  logic                 item_pressed;
  logic [ELAPSED_W-1:0] item_elapsed;
  logic [MASK_W-1:0]    item_mask;
  logic [AW-1:0]        item_addr;

  logic              accept;
  logic              key_in_range;
  logic              out_load;
  logic [GS_W-1:0]   q_gesture;
  logic [7:0]        mask_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign key_in_range = (32'(key) < 32'(NUM_KEYS));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.long_press <= LONG_PRESS_RESET;
      thresh.double_win <= DOUBLE_WIN_RESET;
      blocked           <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LONG_PRESS: thresh.long_press <= cfg_data;
        CFG_DOUBLE_WIN: thresh.double_win <= cfg_data;
        CFG_BLOCKED:    blocked           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_in_range <= key_in_range;
      item_pressed  <= pressed;
      item_elapsed  <= elapsed;
      item_mask     <= state_mask;
      item_addr     <= AW'(key);
    end
  end

  kgt_step u_step (
    .cur     (rd_data),
    .elapsed (item_elapsed),
    .thresh  (thresh),
    .nxt     (adv)
  );

  always_comb begin
    st_next  = st;
    idx_next = idx;
    rd_en    = 1'b0;
    rd_addr  = AW'(key);
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_data  = adv;
    out_load = 1'b0;
    case (st)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (idx == LAST) begin
          st_next  = ST_IDLE;
          idx_next = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_CHANGE: begin
              if (key_in_range) begin
                rd_en   = 1'b1;
                st_next = ST_CHANGE;
              end
            end
            KIND_TICK: begin
              rd_en    = 1'b1;
              rd_addr  = '0;
              idx_next = '0;
              st_next  = ST_SWEEP;
            end
            KIND_QUERY: begin
              rd_en   = 1'b1;
              st_next = ST_QUERY;
            end
            default: ;
          endcase
        end
      end
      ST_CHANGE: begin
        wr_en               = 1'b1;
        wr_addr             = item_addr;
        wr_data             = rd_data;
        wr_data.level       = item_pressed;
        wr_data.event_timer = '0;
        st_next             = ST_IDLE;
      end
      ST_QUERY: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        wr_en = 1'b1;
        if (idx == LAST) begin
          st_next  = ST_IDLE;
          idx_next = '0;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx + 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        st_next  = ST_CLEAR;
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_CLEAR;
      idx <= '0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // query result
  always_comb begin
    q_gesture = rd_data.gesture;
    if (q_gesture == G_CLICK && rd_data.state_timer != '0) begin
      q_gesture = G_INITIAL;
    end
    mask_ext = {1'b0, item_mask};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (item_in_range) begin
        gesture_state <= q_gesture;
        matches_res   <= !blocked && mask_ext[q_gesture];
        held          <= rd_data.level;
        held_time     <= rd_data.event_timer;
      end else begin
        gesture_state <= '0;
        matches_res   <= 1'b0;
        held          <= 1'b0;
        held_time     <= '0;
      end
    end
  end

  `KGT_ASSERT_SAME(a_rw_distinct, wr_en && rd_en, wr_addr != rd_addr, "read and write collide")
  `KGT_ASSERT_NEXT(a_query_done, out_load, out_valid && st == ST_IDLE, "query result not loaded")
  `KGT_ASSERT_NEXT(a_sweep_end, st == ST_SWEEP && idx == LAST, st == ST_IDLE, "sweep overrun")
  `KGT_ASSERT_NEVER(a_load_busy, out_load && out_valid && !out_ready, "result overwritten")

endmodule

`default_nettype wire

// ===== rtl/core/kgt_step.sv =====
`default_nettype none

module kgt_step (
  input  kgt_pkg::entry_t                     cur,
  input  logic [kgt_pkg::ELAPSED_W-1:0]       elapsed,
  input  kgt_pkg::thresh_t                    thresh,
  output kgt_pkg::entry_t                     nxt
);
  import kgt_pkg::*;

  logic [TIME_W:0]   st_sum;
  logic [TIME_W:0]   ev_sum;
  logic [TIME_W-1:0] st_sat;
  logic [TIME_W-1:0] ev_sat;

  always_comb begin
    st_sum = {1'b0, cur.state_timer} + (TIME_W+1)'(elapsed);
    ev_sum = {1'b0, cur.event_timer} + (TIME_W+1)'(elapsed);
    st_sat = st_sum[TIME_W] ? '1 : st_sum[TIME_W-1:0];
    ev_sat = ev_sum[TIME_W] ? '1 : ev_sum[TIME_W-1:0];
  end

  always_comb begin
    nxt             = cur;
    nxt.event_timer = ev_sat;
    nxt.state_timer = st_sat;
    case (cur.gesture)
      G_PRESS, G_DPRESS: begin
        if (cur.level && st_sat >= thresh.long_press) begin
          nxt.gesture     = G_LPRESS;
          nxt.state_timer = '0;
        end else if (!cur.level) begin
          nxt.gesture     = (cur.gesture == G_PRESS) ? G_CLICK : G_DCLICK;
          nxt.state_timer = '0;
        end
      end
      G_CLICK: begin
        if (cur.level && st_sat < thresh.double_win) begin
          nxt.gesture     = G_DPRESS;
          nxt.state_timer = '0;
        end else if (st_sat >= thresh.double_win) begin
          nxt.gesture     = G_INITIAL;
          nxt.state_timer = '0;
        end
      end
      G_DCLICK, G_LCLICK: begin
        if (st_sat != '0) begin
          nxt.gesture     = G_INITIAL;
          nxt.state_timer = '0;
        end
      end
      G_LPRESS: begin
        if (!cur.level) begin
          nxt.gesture     = G_LCLICK;
          nxt.state_timer = '0;
        end
      end
      default: begin
        if (cur.level) begin
          nxt.gesture     = G_PRESS;
          nxt.state_timer = '0;
        end else begin
          nxt.gesture = G_INITIAL;
        end
      end
    endcase
  end

endmodule

`default_nettype wire
